/* sv/move_stack_backtracker_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef MOVE_STACK_BACKTRACKER_TOP_MACROS_SVH
`define MOVE_STACK_BACKTRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/msb_pkg.sv */
package msb_pkg;

	// Default stack depth.
	localparam int STACK_DEPTH_DEF = 64;

	// Field widths.
	localparam int HD_W    = 2;
	localparam int DIST_W  = 24;
	localparam int COORD_W = 32;
	localparam int ENTRY_W = 7;
	localparam int MOVE_W  = HD_W + DIST_W;

	// Stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = ((MOVE_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = HD_W + DIST_W + 2 * COORD_W + ENTRY_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// Input kind on s_tuser.
	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_BACK = 1'b1;

	// Headings; bit 1 selects the east/west axis, bit 0 the negative sense.
	typedef enum logic [HD_W-1:0] {
		HD_NORTH = 2'd0,
		HD_SOUTH = 2'd1,
		HD_EAST  = 2'd2,
		HD_WEST  = 2'd3
	} heading_t;

	// Result status on m_tuser.
	typedef enum logic [1:0] {
		STAT_ADDED = 2'd0,
		STAT_STEP  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_BACK,
		S_STEP
	} state_t;

endpackage

/* sv/move_stack_backtracker_top.sv */
// Move stack backtracker. An input beat with s_tuser = 0 pushes a move (heading and
// distance, fixed point) onto a stack and returns one beat with the updated X/Y position;
// a push onto a full stack is refused with status 3. A beat with s_tuser = 1 pops every
// stored move, newest first, and returns one beat per move with the inverted heading, the
// distance and the position after stepping back, tlast on the final one; on an empty
// stack it returns a single status 2 beat. All coordinate updates run through one shared
// 32-bit add/subtract unit under a small sequencer, and the stack sits in a memory with a
// registered read port. An add or a refused add is accepted, then resolved in S_ADD, which
// loads the result beat; a backtrack is accepted, issues the first memory read in S_BACK,
// then sends one entry per cycle through the adder in S_STEP while the output is not
// stalled; an empty backtrack loads its status beat from S_BACK. s_tready is high only
// while the sequencer is idle; output back-pressure stalls every step that loads a result.
module move_stack_backtracker_top #(
	parameter int STACK_DEPTH = msb_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: heading[1:0], distance[25:2], zero pad
	input  logic [msb_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: mode
	input  logic                          s_tuser,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// m_tdata: step_heading[1:0], step_distance[25:2], pos_x[57:26], pos_y[89:58],
	//          entries[96:90], zero pad
	output logic [msb_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tuser: status
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready
);
	import msb_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PAD_W = OUT_DATA_W - OUT_RAW_W;

	state_t state_q, state_c;

	logic [CNT_W-1:0]   count_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [HD_W-1:0]    in_hd_q;
	logic [DIST_W-1:0]  in_dist_q;
	logic               in_mode_q;
	logic [MOVE_W-1:0]  rd_q;
	logic [MOVE_W-1:0]  mem [STACK_DEPTH];

	logic               out_free;
	logic               in_acc;
	logic               stack_full;
	logic               stack_empty;
	logic [CNT_W-1:0]   cnt_dec;

	// Control from the sequencer.
	logic               ready_c;
	logic               load_c;
	logic               push_c;
	logic               unit_en_c;
	logic               rd_issue_c;
	status_t            stat_c;

	// Shared unit signals.
	logic [HD_W-1:0]    unit_hd;
	logic [DIST_W-1:0]  unit_dist;
	logic [COORD_W-1:0] unit_a;
	logic [COORD_W-1:0] unit_b;
	logic [COORD_W-1:0] unit_sum;

	// Next output beat.
	logic [COORD_W-1:0] x_c, y_c;
	logic [CNT_W-1:0]   count_c;

	// Output register.
	logic               m_valid_q;
	logic [HD_W-1:0]    o_hd_q;
	logic [DIST_W-1:0]  o_dist_q;
	logic [COORD_W-1:0] o_x_q, o_y_q;
	logic [ENTRY_W-1:0] o_ent_q;
	logic               o_last_q;
	status_t            o_stat_q;

	assign out_free    = !m_valid_q || m_tready;
	assign in_acc      = s_tvalid && ready_c;
	assign stack_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign stack_empty = (count_q == '0);
	assign cnt_dec     = count_q - CNT_W'(1);

	// Next state.
	always_comb begin
		state_c = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_c = (s_tuser == MODE_BACK) ? S_BACK : S_ADD;
				end
			end
			S_ADD: begin
				if (out_free) begin
					state_c = S_IDLE;
				end
			end
			S_BACK: begin
				if (!stack_empty) begin
					state_c = S_STEP;
				end else if (out_free) begin
					state_c = S_IDLE;
				end
			end
			S_STEP: begin
				if (out_free && stack_empty) begin
					state_c = S_IDLE;
				end
			end
			default: state_c = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ready_c    = 1'b0;
		load_c     = 1'b0;
		push_c     = 1'b0;
		unit_en_c  = 1'b0;
		rd_issue_c = 1'b0;
		stat_c     = STAT_ADDED;
		case (state_q)
			S_IDLE: ready_c = 1'b1;
			S_ADD: begin
				if (out_free) begin
					load_c = 1'b1;
					if (stack_full) begin
						stat_c = STAT_FULL;
					end else begin
						push_c    = 1'b1;
						unit_en_c = 1'b1;
						stat_c    = STAT_ADDED;
					end
				end
			end
			S_BACK: begin
				stat_c = STAT_EMPTY;
				if (stack_empty) begin
					load_c = out_free;
				end else begin
					rd_issue_c = 1'b1;
				end
			end
			S_STEP: begin
				stat_c = STAT_STEP;
				if (out_free) begin
					load_c     = 1'b1;
					unit_en_c  = 1'b1;
					rd_issue_c = !stack_empty;
				end
			end
			default: ready_c = 1'b0;
		endcase
	end

	// Shared add/subtract unit: pick the axis, add or subtract the distance.
	assign unit_hd   = (state_q == S_STEP) ? (rd_q[MOVE_W-1:DIST_W] ^ HD_W'(1)) : in_hd_q;
	assign unit_dist = (state_q == S_STEP) ? rd_q[DIST_W-1:0] : in_dist_q;
	assign unit_a    = unit_hd[1] ? x_q : y_q;
	assign unit_b    = COORD_W'(unit_dist);
	assign unit_sum  = unit_hd[0] ? (unit_a - unit_b) : (unit_a + unit_b);

	// Position and count after this beat.
	always_comb begin
		x_c = x_q;
		y_c = y_q;
		if (unit_en_c) begin
			if (unit_hd[1]) begin
				x_c = unit_sum;
			end else begin
				y_c = unit_sum;
			end
		end
		count_c = count_q;
		if (push_c) begin
			count_c = count_q + CNT_W'(1);
		end else if (rd_issue_c) begin
			count_c = cnt_dec;
		end
	end

	// Hold sequencer state, stack count and position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else begin
			state_q <= state_c;
			count_q <= count_c;
			x_q     <= x_c;
			y_q     <= y_c;
		end
	end

	// Capture the accepted beat.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_mode_q <= s_tuser;
			in_hd_q   <= s_tdata[HD_W-1:0];
			in_dist_q <= s_tdata[MOVE_W-1:HD_W];
		end
	end

	// Stack memory: write on push, registered read on pop.
	always_ff @(posedge clk) begin
		if (push_c) begin
			mem[count_q[IDX_W-1:0]] <= {in_hd_q, in_dist_q};
		end
		if (rd_issue_c) begin
			rd_q <= mem[cnt_dec[IDX_W-1:0]];
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_c) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload; a step beat reports the entries left below the popped one.
	always_ff @(posedge clk) begin
		if (load_c) begin
			o_stat_q <= stat_c;
			o_hd_q   <= (stat_c == STAT_STEP) ? unit_hd : '0;
			o_dist_q <= (stat_c == STAT_STEP) ? unit_dist : '0;
			o_x_q    <= x_c;
			o_y_q    <= y_c;
			o_ent_q  <= (stat_c == STAT_STEP) ? ENTRY_W'(count_q) : ENTRY_W'(count_c);
			o_last_q <= (stat_c != STAT_STEP) || (count_q == '0) || (in_mode_q == MODE_ADD);
		end
	end

	assign s_tready = ready_c;
	assign m_tvalid = m_valid_q;
	assign m_tuser  = o_stat_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {{PAD_W{1'b0}}, o_ent_q, o_y_q, o_x_q, o_dist_q, o_hd_q};

endmodule

/* sv/msb_checker.sv */
`include "move_stack_backtracker_top_macros.svh"

module msb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic [msb_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                          s_tuser,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [msb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                    m_tuser,
	input logic                          m_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready
);
	import msb_pkg::*;

	logic is_step;
	logic is_empty;

	assign is_step  = (m_tuser == STAT_STEP);
	assign is_empty = (m_tuser == STAT_EMPTY);

	// A stalled result beat holds its payload.
	`MSB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")

	// The block is busy in the cycle after it takes an input beat.
	`MSB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

	// Every non-step result is the single, final beat of its input.
	`MSB_ASSERT_IMPLY(a_single_last, clk, arst_n, m_tvalid && !is_step, m_tlast, "non-step result without tlast")

	// An empty-stack result carries no step and no entries.
	`MSB_ASSERT_IMPLY(a_empty_fields, clk, arst_n, m_tvalid && is_empty, (m_tdata[25:0] == '0) && (m_tdata[96:90] == '0), "empty result carries data")

	// tlast on a step beat means the stack is drained.
	`MSB_ASSERT_IMPLY(a_step_last, clk, arst_n, m_tvalid && is_step, m_tlast == (m_tdata[96:90] == '0), "step tlast disagrees with entries")

endmodule

bind move_stack_backtracker_top msb_checker u_msb_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import msb_pkg::*;

	localparam int DEPTH       = STACK_DEPTH_DEF;
	localparam int RAND_ITEMS  = 140;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	// One result beat as seen on the master side
	typedef struct packed {
		status_t     status;
		heading_t    hd;
		logic [23:0] distance;
		logic [31:0] x;
		logic [31:0] y;
		logic [6:0]  entries;
		logic        last;
	} beat_t;

	// Directed row; typed rows carry their single expected beat
	typedef struct packed {
		logic        md;
		heading_t    hd;
		logic [23:0] distance;
		logic        typed;
		status_t     st;
		logic [31:0] x;
		logic [31:0] y;
		logic [6:0]  ent;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic [IN_DATA_W-1:0]    s_tdata;
	logic                    s_tuser;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic [1:0]              m_tuser;
	logic                    m_tlast;
	logic                    m_tvalid;
	logic                    m_tready;

	// Shadow of the stack and the position
	logic [25:0] trail_mem [DEPTH];
	int          trail_cnt;
	logic [31:0] cur_x;
	logic [31:0] cur_y;

	beat_t       pending_beats [$];
	stim_row_t   dir_tab [16];

	int mismatch_cnt;
	int quiet_cycles;
	int n_adds, n_backs, n_steps, n_full, n_empty, n_out, deepest;
	bit idle_on;

	move_stack_backtracker_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_cnt < 30)
			$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Move the shadow position by one step
	task automatic shift_pos(input heading_t hd, input logic [23:0] distance);
		case (hd)
			HD_NORTH: cur_y = cur_y + {8'd0, distance};
			HD_SOUTH: cur_y = cur_y - {8'd0, distance};
			HD_EAST:  cur_x = cur_x + {8'd0, distance};
			default:  cur_x = cur_x - {8'd0, distance};
		endcase
	endtask

	function automatic beat_t make_beat(input status_t st, input heading_t hd,
			input logic [23:0] distance, input int left, input logic fin);
		beat_t b;
		b.status   = st;
		b.hd       = hd;
		b.distance = distance;
		b.x        = cur_x;
		b.y        = cur_y;
		b.entries  = 7'(left);
		b.last     = fin;
		return b;
	endfunction

	// Apply one accepted move or backtrack and queue the beats it causes
	task automatic apply_move(input logic md, input heading_t hd,
			input logic [23:0] distance);
		heading_t back_hd;
		logic [23:0] back_dist;
		if (md == MODE_ADD) begin
			n_adds++;
			if (trail_cnt >= DEPTH) begin
				n_full++;
				pending_beats.push_back(make_beat(STAT_FULL, HD_NORTH, '0, trail_cnt, 1'b1));
			end else begin
				trail_mem[trail_cnt] = {hd, distance};
				trail_cnt++;
				if (trail_cnt > deepest)
					deepest = trail_cnt;
				shift_pos(hd, distance);
				pending_beats.push_back(make_beat(STAT_ADDED, HD_NORTH, '0, trail_cnt, 1'b1));
			end
		end else begin
			n_backs++;
			if (trail_cnt == 0) begin
				n_empty++;
				pending_beats.push_back(make_beat(STAT_EMPTY, HD_NORTH, '0, 0, 1'b1));
			end
			// Unwind newest first, stepping the opposite way
			while (trail_cnt > 0) begin
				trail_cnt--;
				case (heading_t'(trail_mem[trail_cnt][25:24]))
					HD_NORTH: back_hd = HD_SOUTH;
					HD_SOUTH: back_hd = HD_NORTH;
					HD_EAST:  back_hd = HD_WEST;
					default:  back_hd = HD_EAST;
				endcase
				back_dist = trail_mem[trail_cnt][23:0];
				shift_pos(back_hd, back_dist);
				n_steps++;
				pending_beats.push_back(make_beat(STAT_STEP, back_hd, back_dist, trail_cnt,
					trail_cnt == 0));
			end
		end
	endtask

	// Present one beat, wait for the handshake, then predict
	task automatic send_beat(input logic md, input heading_t hd,
			input logic [23:0] distance);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {{(IN_DATA_W - MOVE_W){1'b0}}, distance, hd};
		do @(posedge clk); while (!s_tready);
		apply_move(md, hd, distance);
		@(negedge clk);
	endtask

	function automatic logic [23:0] pick_dist();
		case ($urandom_range(0, 5))
			0:       return 24'hFFFFFF;
			1:       return 24'h000000;
			2:       return 24'($urandom_range(0, 255));
			default: return 24'($urandom);
		endcase
	endfunction

	// Stimulus: reset, directed table, full-stack fill, then random runs
	initial begin
		int i, run_len, pick, rand_items;
		bit paused;
		beat_t typed_beat;
		s_tvalid     = 1'b0;
		s_tuser      = MODE_ADD;
		s_tdata      = '0;
		arst_n       = 1'b0;
		trail_cnt    = 0;
		cur_x        = '0;
		cur_y        = '0;
		mismatch_cnt = 0;
		n_adds = 0; n_backs = 0; n_steps = 0; n_full = 0; n_empty = 0; n_out = 0;
		deepest      = 0;
		idle_on      = 1'b1;
		rand_items   = 0;
		paused       = 1'b0;

		dir_tab = '{
			'{MODE_BACK, HD_WEST,  24'hFFFFFF, 1'b1, STAT_EMPTY, 32'h0, 32'h0, 7'd0},
			'{MODE_ADD,  HD_NORTH, 24'hFFFFFF, 1'b1, STAT_ADDED, 32'h0, 32'h00FFFFFF, 7'd1},
			'{MODE_ADD,  HD_SOUTH, 24'hFFFFFF, 1'b1, STAT_ADDED, 32'h0, 32'h0, 7'd2},
			'{MODE_ADD,  HD_EAST,  24'hFFFFFF, 1'b1, STAT_ADDED, 32'h00FFFFFF, 32'h0, 7'd3},
			'{MODE_ADD,  HD_WEST,  24'hFFFFFF, 1'b1, STAT_ADDED, 32'h0, 32'h0, 7'd4},
			'{MODE_ADD,  HD_WEST,  24'h000001, 1'b1, STAT_ADDED, 32'hFFFFFFFF, 32'h0, 7'd5},
			'{MODE_ADD,  HD_SOUTH, 24'h000000, 1'b1, STAT_ADDED, 32'hFFFFFFFF, 32'h0, 7'd6},
			'{MODE_ADD,  HD_NORTH, 24'h000100, 1'b1, STAT_ADDED, 32'hFFFFFFFF, 32'h100, 7'd7},
			'{MODE_ADD,  HD_EAST,  24'h800000, 1'b1, STAT_ADDED, 32'h007FFFFF, 32'h100, 7'd8},
			'{MODE_BACK, HD_NORTH, 24'h000000, 1'b0, STAT_STEP,  32'h0, 32'h0, 7'd0},
			'{MODE_BACK, HD_SOUTH, 24'h5A5A5A, 1'b1, STAT_EMPTY, 32'h0, 32'h0, 7'd0},
			'{MODE_ADD,  HD_WEST,  24'hAAAAAA, 1'b1, STAT_ADDED, 32'hFF555556, 32'h0, 7'd1},
			'{MODE_ADD,  HD_SOUTH, 24'h555555, 1'b1, STAT_ADDED, 32'hFF555556, 32'hFFAAAAAB, 7'd2},
			'{MODE_BACK, HD_EAST,  24'hFFFFFF, 1'b0, STAT_STEP,  32'h0, 32'h0, 7'd0},
			'{MODE_ADD,  HD_NORTH, 24'h123456, 1'b1, STAT_ADDED, 32'h0, 32'h00123456, 7'd1},
			'{MODE_BACK, HD_WEST,  24'h000000, 1'b0, STAT_STEP,  32'h0, 32'h0, 7'd0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows; typed rows replace the predicted beat
		for (i = 0; i < 16; i++) begin
			send_beat(dir_tab[i].md, dir_tab[i].hd, dir_tab[i].distance);
			if (dir_tab[i].typed) begin
				typed_beat = '{dir_tab[i].st, HD_NORTH, 24'h0, dir_tab[i].x, dir_tab[i].y,
					dir_tab[i].ent, 1'b1};
				void'(pending_beats.pop_back());
				pending_beats.push_back(typed_beat);
			end
		end

		// Fill the stack, push past it twice, then unwind it all
		repeat (DEPTH) send_beat(MODE_ADD, heading_t'($urandom_range(0, 3)), pick_dist());
		repeat (2) send_beat(MODE_ADD, heading_t'($urandom_range(0, 3)), pick_dist());
		send_beat(MODE_BACK, heading_t'($urandom_range(0, 3)), pick_dist());

		// Random runs of pushes closed by a backtrack, with some stray beats
		while (rand_items < RAND_ITEMS) begin
			if (!paused && rand_items >= 50) begin
				s_tvalid <= 1'b0;
				while (pending_beats.size() != 0) @(posedge clk);
				@(negedge clk);
				paused = 1'b1;
			end
			if (rand_items >= 110)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_beat(logic'($urandom_range(0, 1)), heading_t'($urandom_range(0, 3)),
					pick_dist());
				rand_items++;
			end else begin
				if (pick < 25)
					run_len = $urandom_range(40, 66);
				else if (pick < 40)
					run_len = $urandom_range(9, 20);
				else
					run_len = $urandom_range(0, 8);
				repeat (run_len) begin
					send_beat(MODE_ADD, heading_t'($urandom_range(0, 3)), pick_dist());
					rand_items++;
				end
				send_beat(MODE_BACK, heading_t'($urandom_range(0, 3)), pick_dist());
				rand_items++;
			end
		end
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any stray beat
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d pushes (%0d refused on a full stack), %0d backtracks",
			n_adds, n_full, n_backs);
		$display("  (%0d on an empty stack), %0d unwind steps, %0d result beats, depth %0d",
			n_empty, n_steps, n_out, deepest);
		if (mismatch_cnt == 0)
			$display("** move_stack_backtracker_top: PASSED **");
		else
			$display("** move_stack_backtracker_top: FAILED **");
		$finish;
	end

	// Receiver back-pressure in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		beat_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			n_out++;
			got.status   = status_t'(m_tuser);
			got.hd       = heading_t'(m_tdata[1:0]);
			got.distance = m_tdata[25:2];
			got.x        = m_tdata[57:26];
			got.y        = m_tdata[89:58];
			got.entries  = m_tdata[96:90];
			got.last     = m_tlast;
			if (pending_beats.size() == 0) begin
				flag_mismatch("unexpected beat", got.x, 32'h0);
			end else begin
				want = pending_beats.pop_front();
				if (got.status !== want.status)
					flag_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.hd !== want.hd)
					flag_mismatch("step_heading", 32'(got.hd), 32'(want.hd));
				if (got.distance !== want.distance)
					flag_mismatch("step_distance", 32'(got.distance), 32'(want.distance));
				if (got.x !== want.x)
					flag_mismatch("pos_x", got.x, want.x);
				if (got.y !== want.y)
					flag_mismatch("pos_y", got.y, want.y);
				if (got.entries !== want.entries)
					flag_mismatch("entries", 32'(got.entries), 32'(want.entries));
				if (got.last !== want.last)
					flag_mismatch("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, pending_beats.size());
			$display("** move_stack_backtracker_top: FAILED **");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
